// ----- src/stt_pkg.sv -----
`default_nettype none
package stt_pkg;

   localparam int TEXT_LIMIT    = 32;
   localparam int POSITION_BITS = 16;
   localparam int COUNT_BITS    = $clog2(TEXT_LIMIT);
   localparam int START_BITS    = 16;
   localparam int LEN_BITS      = 5;
   localparam int KIND_BITS     = 5;
   localparam int VALUE_BITS    = 32;
   localparam int SLOTS         = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_COMMENT,
      MODE_SLASH, MODE_MINUS, MODE_TILDE, MODE_GT, MODE_LT, MODE_EQ
   } mode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_IDENT   = 5'd0,
      KIND_NUMBER  = 5'd1,
      KIND_STRING  = 5'd2,
      KIND_COLON   = 5'd3,
      KIND_ARROW   = 5'd4,
      KIND_TAP     = 5'd5,
      KIND_STAR    = 5'd6,
      KIND_PLUS    = 5'd7,
      KIND_MINUS   = 5'd8,
      KIND_LPAREN  = 5'd9,
      KIND_RPAREN  = 5'd10,
      KIND_LBRACE  = 5'd11,
      KIND_RBRACE  = 5'd12,
      KIND_COMMA   = 5'd13,
      KIND_GT      = 5'd14,
      KIND_LT      = 5'd15,
      KIND_EQ      = 5'd16,
      KIND_GTE     = 5'd17,
      KIND_LTE     = 5'd18,
      KIND_NEWLINE = 5'd19,
      KIND_END     = 5'd20
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [VALUE_BITS-1:0]   value;
      logic [START_BITS-1:0]   start;
      logic [LEN_BITS-1:0]     length;
      logic                    last;
   } tok_type;

   // tokens caused by one source word, packed from slot zero upward
   typedef struct packed {
      tok_type [SLOTS-1:0] slot;
      logic    [SLOTS-1:0] valid;
   } rec_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
   endfunction

   function automatic logic [START_BITS-1:0] to_start(input logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS+START_BITS-1:0] wide;
      wide = (POSITION_BITS+START_BITS)'(p);
      return wide[START_BITS-1:0];
   endfunction

   function automatic logic [LEN_BITS-1:0] to_len(input logic [COUNT_BITS-1:0] n);
      logic [COUNT_BITS+LEN_BITS-1:0] wide;
      wide = (COUNT_BITS+LEN_BITS)'(n);
      return wide[LEN_BITS-1:0];
   endfunction

   function automatic tok_type make_tok(input kind_type k,
                                        input logic [VALUE_BITS-1:0] v,
                                        input logic [POSITION_BITS-1:0] p,
                                        input logic [LEN_BITS-1:0] n);
      tok_type t;
      t.kind   = k;
      t.value  = v;
      t.start  = to_start(p);
      t.length = n;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage
`default_nettype wire

// ----- src/stt_front.sv -----
`default_nettype none
module stt_front
   import stt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_byte,
   input  wire logic       end_of_input,
   output rec_type         rec,
   output logic            rec_write
);

   mode_type                  mode_ff, mode_in;
   logic [POSITION_BITS-1:0]  start_ff, start_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [VALUE_BITS-1:0]     acc_ff, acc_in;
   logic [POSITION_BITS-1:0]  pos_ff, pos_in;
   logic                      done_ff, done_in;

   // close of pending token, single from fresh scan, flush at end, end token
   tok_type    cand [4];
   logic [3:0] cand_v;

   // next state of the scanner
   always_comb begin
      logic fresh;
      mode_in  = mode_ff;
      start_in = start_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      done_in  = done_ff;
      fresh    = 1'b0;
      if (!done_ff) begin
         if (char_byte != CH_NUL) begin
            unique case (mode_ff) inside
               MODE_IDENT: begin
                  if (is_alpha(char_byte) || is_digit(char_byte)) begin
                     if (count_ff != COUNT_BITS'(TEXT_LIMIT-1)) count_in = count_ff + 1'b1;
                  end else begin
                     fresh = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(char_byte)) begin
                     acc_in = (acc_ff << 3) + (acc_ff << 1) +
                              VALUE_BITS'(char_byte - CH_ZERO);
                     if (count_ff != COUNT_BITS'(TEXT_LIMIT-1)) count_in = count_ff + 1'b1;
                  end else begin
                     fresh = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (char_byte == CH_QUOTE) begin
                     mode_in = MODE_IDLE;
                  end else if (count_ff != COUNT_BITS'(TEXT_LIMIT-1)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (char_byte == CH_NL) mode_in = MODE_IDLE;
               end
               MODE_SLASH: begin
                  if (char_byte == CH_SLASH) mode_in = MODE_COMMENT;
                  else fresh = 1'b1;
               end
               MODE_MINUS, MODE_TILDE: begin
                  if (char_byte == CH_GT) mode_in = MODE_IDLE;
                  else fresh = 1'b1;
               end
               MODE_GT, MODE_LT, MODE_EQ: begin
                  if (char_byte == CH_EQUAL) mode_in = MODE_IDLE;
                  else fresh = 1'b1;
               end
               default: fresh = 1'b1;
            endcase
            if (fresh) begin
               mode_in  = MODE_IDLE;
               start_in = pos_ff;
               unique case (char_byte)
                  CH_SLASH: mode_in = MODE_SLASH;
                  CH_MINUS: mode_in = MODE_MINUS;
                  CH_TILDE: mode_in = MODE_TILDE;
                  CH_GT:    mode_in = MODE_GT;
                  CH_LT:    mode_in = MODE_LT;
                  CH_EQUAL: mode_in = MODE_EQ;
                  CH_QUOTE: begin
                     mode_in  = MODE_STRING;
                     start_in = pos_ff + 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     if (is_digit(char_byte)) begin
                        mode_in  = MODE_NUMBER;
                        acc_in   = VALUE_BITS'(char_byte - CH_ZERO);
                        count_in = COUNT_BITS'(1);
                     end else if (is_alpha(char_byte)) begin
                        mode_in  = MODE_IDENT;
                        count_in = COUNT_BITS'(1);
                     end
                  end
               endcase
            end
            pos_in = pos_ff + 1'b1;
         end
         if ((char_byte == CH_NUL) || end_of_input) begin
            // scanner freezes; the scanned mode tells the token block what to flush
            done_in = 1'b1;
         end
      end
   end

   // tokens produced by this word
   always_comb begin
      logic     fresh;
      mode_type mid_mode;
      cand_v   = '0;
      fresh    = 1'b0;
      mid_mode = mode_ff;
      for (int k = 0; k < 4; k++) begin
         cand[k] = make_tok(KIND_END, '0, pos_ff, '0);
      end
      if (!done_ff) begin
         if (char_byte != CH_NUL) begin
            unique case (mode_ff)
               MODE_IDENT: begin
                  if (!(is_alpha(char_byte) || is_digit(char_byte))) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_IDENT, '0, start_ff, to_len(count_ff));
                     fresh     = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (!is_digit(char_byte)) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_NUMBER, acc_ff, start_ff, to_len(count_ff));
                     fresh     = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (char_byte == CH_QUOTE) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_STRING, '0, start_ff, to_len(count_ff));
                     mid_mode  = MODE_IDLE;
                  end
               end
               MODE_COMMENT: begin
                  if (char_byte == CH_NL) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_NEWLINE, '0, start_ff, LEN_BITS'(1));
                     mid_mode  = MODE_IDLE;
                  end
               end
               MODE_SLASH: begin
                  if (char_byte == CH_SLASH) mid_mode = MODE_COMMENT;
                  else fresh = 1'b1;
               end
               MODE_MINUS: begin
                  cand_v[0] = 1'b1;
                  if (char_byte == CH_GT) begin
                     cand[0]  = make_tok(KIND_ARROW, '0, start_ff, LEN_BITS'(2));
                     mid_mode = MODE_IDLE;
                  end else begin
                     cand[0] = make_tok(KIND_MINUS, '0, start_ff, LEN_BITS'(1));
                     fresh   = 1'b1;
                  end
               end
               MODE_TILDE: begin
                  if (char_byte == CH_GT) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_TAP, '0, start_ff, LEN_BITS'(2));
                     mid_mode  = MODE_IDLE;
                  end else begin
                     fresh = 1'b1;
                  end
               end
               MODE_GT: begin
                  cand_v[0] = 1'b1;
                  if (char_byte == CH_EQUAL) begin
                     cand[0]  = make_tok(KIND_GTE, '0, start_ff, LEN_BITS'(2));
                     mid_mode = MODE_IDLE;
                  end else begin
                     cand[0] = make_tok(KIND_GT, '0, start_ff, LEN_BITS'(1));
                     fresh   = 1'b1;
                  end
               end
               MODE_LT: begin
                  cand_v[0] = 1'b1;
                  if (char_byte == CH_EQUAL) begin
                     cand[0]  = make_tok(KIND_LTE, '0, start_ff, LEN_BITS'(2));
                     mid_mode = MODE_IDLE;
                  end else begin
                     cand[0] = make_tok(KIND_LT, '0, start_ff, LEN_BITS'(1));
                     fresh   = 1'b1;
                  end
               end
               MODE_EQ: begin
                  if (char_byte == CH_EQUAL) begin
                     cand_v[0] = 1'b1;
                     cand[0]   = make_tok(KIND_EQ, '0, start_ff, LEN_BITS'(2));
                     mid_mode  = MODE_IDLE;
                  end else begin
                     fresh = 1'b1;
                  end
               end
               default: fresh = 1'b1;
            endcase
            if (fresh) begin
               cand[1] = make_tok(KIND_NEWLINE, '0, pos_ff, LEN_BITS'(1));
               unique case (char_byte)
                  CH_NL:     cand_v[1] = 1'b1;
                  CH_COLON:  begin cand_v[1] = 1'b1; cand[1].kind = KIND_COLON;  end
                  CH_STAR:   begin cand_v[1] = 1'b1; cand[1].kind = KIND_STAR;   end
                  CH_PLUS:   begin cand_v[1] = 1'b1; cand[1].kind = KIND_PLUS;   end
                  CH_LPAREN: begin cand_v[1] = 1'b1; cand[1].kind = KIND_LPAREN; end
                  CH_RPAREN: begin cand_v[1] = 1'b1; cand[1].kind = KIND_RPAREN; end
                  CH_LBRACE: begin cand_v[1] = 1'b1; cand[1].kind = KIND_LBRACE; end
                  CH_RBRACE: begin cand_v[1] = 1'b1; cand[1].kind = KIND_RBRACE; end
                  CH_COMMA:  begin cand_v[1] = 1'b1; cand[1].kind = KIND_COMMA;  end
                  default: ;
               endcase
            end
         end
         if ((char_byte == CH_NUL) || end_of_input) begin
            // flush whatever the scan left pending, then the end marker
            if (char_byte == CH_NUL) mid_mode = mode_ff;
            else mid_mode = mode_in;
            cand[2] = make_tok(KIND_MINUS, '0, start_in, LEN_BITS'(1));
            unique case (mid_mode)
               MODE_IDENT: begin
                  cand_v[2] = 1'b1;
                  cand[2]   = make_tok(KIND_IDENT, '0, start_in, to_len(count_in));
               end
               MODE_NUMBER: begin
                  cand_v[2] = 1'b1;
                  cand[2]   = make_tok(KIND_NUMBER, acc_in, start_in, to_len(count_in));
               end
               MODE_STRING: begin
                  cand_v[2] = 1'b1;
                  cand[2]   = make_tok(KIND_STRING, '0, start_in, to_len(count_in));
               end
               MODE_COMMENT: begin cand_v[2] = 1'b1; cand[2].kind = KIND_NEWLINE; end
               MODE_MINUS:   cand_v[2] = 1'b1;
               MODE_GT:      begin cand_v[2] = 1'b1; cand[2].kind = KIND_GT; end
               MODE_LT:      begin cand_v[2] = 1'b1; cand[2].kind = KIND_LT; end
               default: ;
            endcase
            cand_v[3] = 1'b1;
            cand[3]   = make_tok(KIND_END, '0, pos_in, '0);
         end
      end
   end

   // pack the candidates into the low slots and mark the last one
   always_comb begin
      logic [1:0] idx;
      idx = '0;
      rec = '0;
      for (int k = 0; k < 4; k++) begin
         if (cand_v[k] && (idx != 2'd3)) begin
            rec.slot[idx]  = cand[k];
            rec.valid[idx] = 1'b1;
            idx            = idx + 1'b1;
         end
      end
      rec.slot[0].last = rec.valid[0] && !rec.valid[1];
      rec.slot[1].last = rec.valid[1] && !rec.valid[2];
      rec.slot[2].last = rec.valid[2];
      rec_write = accept && (rec.valid != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         count_ff <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/stt_queue.sv -----
`default_nettype none
module stt_queue
   import stt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    write,
   input  wire rec_type write_rec,
   output logic         full,
   output logic         empty,
   input  wire logic    read,
   output rec_type      head_rec
);

   rec_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (write && !read) count_in = count_ff + 1'b1;
      else if (read && !write) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (write) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (read) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) entry_ff[wr_ptr_ff] <= write_rec;
   end

endmodule
`default_nettype wire

// ----- src/stt_back.sv -----
`default_nettype none
module stt_back
   import stt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire rec_type head_rec,
   output logic         q_read,
   output tok_type      out_tok,
   output logic         out_valid,
   input  wire logic    out_taken
);

   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   tok_type    tok_ff, tok_in;
   tok_type    cur;
   logic       load;

   always_comb begin
      cur      = head_rec.slot[slot_ff];
      load     = !q_empty && (!valid_ff || out_taken);
      q_read   = load && cur.last;
      slot_in  = slot_ff;
      valid_in = valid_ff && !out_taken;
      tok_in   = tok_ff;
      if (load) begin
         tok_in   = cur;
         valid_in = 1'b1;
         slot_in  = cur.last ? 2'd0 : slot_ff + 1'b1;
      end
   end

   assign out_tok   = tok_ff;
   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

endmodule
`default_nettype wire

// ----- src/source_text_tokenizer.sv -----
`default_nettype none
// path: a closing byte's tokens go through the record queue and the back's output register
// throughput: one source byte per cycle while the four-entry record queue has room;
// tokens leave one per cycle while rsp_pop is held; a byte's tokens hold the output side until each has left
// reset: synchronous, clears scanner, queue pointers and output valid flag; no clearing pass,
// the block takes bytes as soon as reset is released
module source_text_tokenizer
   import stt_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // source bytes
   input  wire logic [7:0]                   req_char_byte,
   input  wire logic                         req_end_of_input,
   input  wire logic                         req_push,
   output logic                              req_full,
   // tokens
   output logic [KIND_BITS-1:0]              rsp_token_type,
   output logic signed [VALUE_BITS-1:0]      rsp_number_value,
   output logic [START_BITS-1:0]             rsp_text_start,
   output logic [LEN_BITS-1:0]               rsp_text_length,
   output logic                              rsp_last_of_run,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop
);

   // front: scanner state machine with one-byte lookahead, turns each word
   // into a record of up to three tokens
   logic    accept;
   rec_type front_rec;
   logic    front_write;

   // queue between front and back
   logic    q_full, q_empty, q_read;
   rec_type head_rec;

   // back: walks the head record one token a cycle into the output register while it is free or popped
   tok_type out_tok;
   logic    out_valid;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   stt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_byte    (req_char_byte),
      .end_of_input (req_end_of_input),
      .rec          (front_rec),
      .rec_write    (front_write)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .write     (front_write),
      .write_rec (front_rec),
      .full      (q_full),
      .empty     (q_empty),
      .read      (q_read),
      .head_rec  (head_rec)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_rec  (head_rec),
      .q_read    (q_read),
      .out_tok   (out_tok),
      .out_valid (out_valid),
      .out_taken (rsp_pop)
   );

   // output word straight from the back's register
   assign rsp_empty        = !out_valid;
   assign rsp_token_type   = out_tok.kind;
   assign rsp_number_value = out_tok.value;
   assign rsp_text_start   = out_tok.start;
   assign rsp_text_length  = out_tok.length;
   assign rsp_last_of_run  = out_tok.last;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import stt_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 24;     // drain time after the last owed token
   localparam int HOLD_AFTER   = 150;    // source words accepted before the long hold-off
   localparam int HOLD_CYCLES  = 160;

   // one source word as it waits in the driver queue
   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } src_word_type;

   logic                         clock;
   logic                         reset            = 1'b1;
   logic [7:0]                   req_char_byte    = 8'd0;
   logic                         req_end_of_input = 1'b0;
   logic                         req_push         = 1'b0;
   logic                         req_full;
   logic [KIND_BITS-1:0]         rsp_token_type;
   logic signed [VALUE_BITS-1:0] rsp_number_value;
   logic [START_BITS-1:0]        rsp_text_start;
   logic [LEN_BITS-1:0]          rsp_text_length;
   logic                         rsp_last_of_run;
   logic                         rsp_empty;
   logic                         rsp_pop          = 1'b0;

   source_text_tokenizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_token_type   (rsp_token_type),
      .rsp_number_value (rsp_number_value),
      .rsp_text_start   (rsp_text_start),
      .rsp_text_length  (rsp_text_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // scanner mirror: state of the lexer as the testbench sees it
   // ---------------------------------------------------------------------
   mode_type                 lex_mode  = MODE_IDLE;
   logic [START_BITS-1:0]    lex_start = '0;
   logic [LEN_BITS-1:0]      lex_count = '0;
   logic [VALUE_BITS-1:0]    lex_acc   = '0;
   logic [POSITION_BITS-1:0] lex_pos   = '0;
   logic                     lex_done  = 1'b0;

   tok_type      expected_toks[$];   // tokens still owed by the block, oldest first
   src_word_type pending_words[$];   // source text not yet offered

   int total_words    = 0;
   int accepted_words = 0;
   int tokens_checked = 0;
   int full_cycles    = 0;
   int errors         = 0;

   function automatic logic is_dec_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return c == CH_UNDER || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   task automatic owe_token(input kind_type k, input logic [VALUE_BITS-1:0] v,
                            input logic [START_BITS-1:0] s, input logic [LEN_BITS-1:0] n);
      tok_type t;
      t.kind   = k;
      t.value  = v;
      t.start  = s;
      t.length = n;
      t.last   = 1'b0;
      expected_toks.push_back(t);
   endtask

   // text length saturates one below the text limit
   task automatic grow_text();
      if (int'(lex_count) < TEXT_LIMIT - 1)
         lex_count = lex_count + 1'b1;
   endtask

   // scan one source character at position lex_pos
   task automatic scan_char(input logic [7:0] c);
      logic again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (lex_mode)
            MODE_IDENT:
               if (is_name_char(c) || is_dec_digit(c)) grow_text();
               else begin
                  owe_token(KIND_IDENT, '0, lex_start, lex_count);
                  again = 1'b1;
               end
            MODE_NUMBER:
               if (is_dec_digit(c)) begin
                  lex_acc = lex_acc * 32'd10 + 32'(c - CH_ZERO);
                  grow_text();
               end else begin
                  owe_token(KIND_NUMBER, lex_acc, lex_start, lex_count);
                  again = 1'b1;
               end
            MODE_STRING:
               if (c == CH_QUOTE) begin
                  owe_token(KIND_STRING, '0, lex_start, lex_count);
                  lex_mode = MODE_IDLE;
               end else begin
                  grow_text();
               end
            MODE_COMMENT:
               // whole comment collapses into the newline that ends it
               if (c == CH_NL) begin
                  owe_token(KIND_NEWLINE, '0, lex_start, 5'd1);
                  lex_mode = MODE_IDLE;
               end
            MODE_SLASH:
               if (c == CH_SLASH) lex_mode = MODE_COMMENT;
               else again = 1'b1;   // lone slash is dropped
            MODE_MINUS:
               if (c == CH_GT) begin
                  owe_token(KIND_ARROW, '0, lex_start, 5'd2);
                  lex_mode = MODE_IDLE;
               end else begin
                  owe_token(KIND_MINUS, '0, lex_start, 5'd1);
                  again = 1'b1;
               end
            MODE_TILDE:
               if (c == CH_GT) begin
                  owe_token(KIND_TAP, '0, lex_start, 5'd2);
                  lex_mode = MODE_IDLE;
               end else begin
                  again = 1'b1;
               end
            MODE_GT:
               if (c == CH_EQUAL) begin
                  owe_token(KIND_GTE, '0, lex_start, 5'd2);
                  lex_mode = MODE_IDLE;
               end else begin
                  owe_token(KIND_GT, '0, lex_start, 5'd1);
                  again = 1'b1;
               end
            MODE_LT:
               if (c == CH_EQUAL) begin
                  owe_token(KIND_LTE, '0, lex_start, 5'd2);
                  lex_mode = MODE_IDLE;
               end else begin
                  owe_token(KIND_LT, '0, lex_start, 5'd1);
                  again = 1'b1;
               end
            MODE_EQ:
               if (c == CH_EQUAL) begin
                  owe_token(KIND_EQ, '0, lex_start, 5'd2);
                  lex_mode = MODE_IDLE;
               end else begin
                  again = 1'b1;
               end
            default: begin
               lex_mode  = MODE_IDLE;
               lex_start = lex_pos;
               case (c)
                  CH_SPACE, CH_TAB, CH_CR: ;
                  CH_NL:     owe_token(KIND_NEWLINE, '0, lex_pos, 5'd1);
                  CH_SLASH:  lex_mode = MODE_SLASH;
                  CH_MINUS:  lex_mode = MODE_MINUS;
                  CH_TILDE:  lex_mode = MODE_TILDE;
                  CH_GT:     lex_mode = MODE_GT;
                  CH_LT:     lex_mode = MODE_LT;
                  CH_EQUAL:  lex_mode = MODE_EQ;
                  CH_COLON:  owe_token(KIND_COLON, '0, lex_pos, 5'd1);
                  CH_STAR:   owe_token(KIND_STAR, '0, lex_pos, 5'd1);
                  CH_PLUS:   owe_token(KIND_PLUS, '0, lex_pos, 5'd1);
                  CH_LPAREN: owe_token(KIND_LPAREN, '0, lex_pos, 5'd1);
                  CH_RPAREN: owe_token(KIND_RPAREN, '0, lex_pos, 5'd1);
                  CH_LBRACE: owe_token(KIND_LBRACE, '0, lex_pos, 5'd1);
                  CH_RBRACE: owe_token(KIND_RBRACE, '0, lex_pos, 5'd1);
                  CH_COMMA:  owe_token(KIND_COMMA, '0, lex_pos, 5'd1);
                  CH_QUOTE: begin
                     // string text starts after the quote, wrapping with the position
                     lex_mode  = MODE_STRING;
                     lex_start = lex_pos + 1'b1;
                     lex_count = '0;
                  end
                  default:
                     if (is_dec_digit(c)) begin
                        lex_mode  = MODE_NUMBER;
                        lex_acc   = 32'(c - CH_ZERO);
                        lex_count = 5'd1;
                     end else if (is_name_char(c)) begin
                        lex_mode  = MODE_IDENT;
                        lex_count = 5'd1;
                     end
                     // anything else, high bytes included, is dropped
               endcase
            end
         endcase
         if (again)
            lex_mode = MODE_IDLE;
      end
   endtask

   // expected tokens for one accepted source word
   task automatic predict_word(input logic [7:0] c, input logic eoi);
      int      n_before;
      tok_type t;
      n_before = expected_toks.size();
      if (!lex_done) begin
         if (c != CH_NUL) begin
            scan_char(c);
            lex_pos = lex_pos + 1'b1;
         end
         if (c == CH_NUL || eoi) begin
            // flush whatever is pending, then the end token
            case (lex_mode)
               MODE_IDENT:   owe_token(KIND_IDENT, '0, lex_start, lex_count);
               MODE_NUMBER:  owe_token(KIND_NUMBER, lex_acc, lex_start, lex_count);
               MODE_STRING:  owe_token(KIND_STRING, '0, lex_start, lex_count);
               MODE_COMMENT: owe_token(KIND_NEWLINE, '0, lex_start, 5'd1);
               MODE_MINUS:   owe_token(KIND_MINUS, '0, lex_start, 5'd1);
               MODE_GT:      owe_token(KIND_GT, '0, lex_start, 5'd1);
               MODE_LT:      owe_token(KIND_LT, '0, lex_start, 5'd1);
               default: ;
            endcase
            lex_mode = MODE_IDLE;
            owe_token(KIND_END, '0, lex_pos, 5'd0);
            lex_done = 1'b1;
         end
      end
      if (expected_toks.size() > n_before) begin
         t      = expected_toks.pop_back();
         t.last = 1'b1;
         expected_toks.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------------
   // source text generation
   // ---------------------------------------------------------------------
   task automatic queue_char(input logic [7:0] c, input logic eoi = 1'b0);
      src_word_type w;
      w.ch  = c;
      w.eoi = eoi;
      pending_words.push_back(w);
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         queue_char(s[i]);
   endtask

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // any nonzero byte other than the one that would end the construct
   function automatic logic [7:0] body_byte(input logic [7:0] stop);
      logic [7:0] c;
      c = stop;
      while (c == stop)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic queue_fragment();
      string letters, name_chars, ops[16];
      int    i, n;
      letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      name_chars = {letters, "0123456789"};
      ops = '{"->", "~>", ">=", "<=", "==", ":", "*", "+", "-", "(", ")", "{", "}",
              ",", ">", "<"};
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            // long names now and then so the length saturates
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            queue_char(pick_from(letters));
            for (i = 1; i < n; i++)
               queue_char(pick_from(name_chars));
         end
         3, 4: begin
            // long numbers wrap the 32-bit value
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               queue_char(pick_from("0123456789"));
         end
         5: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
            queue_char(CH_QUOTE);
            for (i = 0; i < n; i++)
               queue_char(body_byte(CH_QUOTE));
            queue_char(CH_QUOTE);
         end
         6, 7, 8, 9: queue_text(ops[$urandom_range(0, 15)]);
         10, 11:     queue_char(pick_from(" \t\r"));
         12, 13:     queue_char(CH_NL);
         14: begin
            queue_text("//");
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
               queue_char(body_byte(CH_NL));
            queue_char(CH_NL);
         end
         15, 16:     queue_char(8'($urandom_range(1, 255)));
         default:    queue_char(pick_from("/~="));   // lone operators, then rescan
      endcase
      // usually a gap, sometimes tokens butt against each other
      if ($urandom_range(0, 2) != 0)
         queue_char(CH_SPACE);
   endtask

   task automatic build_source();
      int         i, mark;
      src_word_type w;
      // short directed opening: every token kind but the end marker, lone operators, high bytes
      queue_text("a:->~>*+-(){},>=<= < > ==\n//\n/ ~ =");
      queue_char(8'hFF);
      queue_char(8'h80);
      queue_text("\"q\"\t\r9 ");
      while (pending_words.size() < 230)
         queue_fragment();
      mark = pending_words.size();
      while (pending_words.size() < mark + 200)
         queue_fragment();
      // something left open when the source ends
      case ($urandom_range(0, 4))
         0: queue_text("\"open");
         1: queue_char(CH_MINUS);
         2: queue_char(pick_from("<>"));
         3: queue_text("// no newline");
         default: queue_text("x7");
      endcase
      // end marked on the last character, or by a zero byte with either flag value
      case ($urandom_range(0, 2))
         0: begin
            w     = pending_words.pop_back();
            w.eoi = 1'b1;
            pending_words.push_back(w);
         end
         1: queue_char(CH_NUL, 1'b0);
         default: queue_char(CH_NUL, 1'b1);
      endcase
      // words after the end must produce nothing
      queue_char(8'($urandom_range(0, 255)), 1'b1);
      for (i = 0; i < 3; i++)
         queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      total_words = pending_words.size();
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of words with random gaps, holds while full
   // ---------------------------------------------------------------------
   int           burst_left = 0;
   int           gap_left   = 0;
   src_word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_push   <= 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (req_push && !req_full) begin
            predict_word(req_char_byte, req_end_of_input);
            accepted_words <= accepted_words + 1;
         end
         if (req_push && req_full)
            full_cycles <= full_cycles + 1;   // word stays on the ports
         else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word         = pending_words.pop_front();
            req_char_byte    <= next_word.ch;
            req_end_of_input <= next_word.eoi;
            req_push         <= 1'b1;
            if (burst_left > 1)
               burst_left--;
            else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall style changes every so often, plus one long hold-off
   // ---------------------------------------------------------------------
   int stall_style = 0;
   int style_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!hold_done && accepted_words >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = $urandom_range(10, 80);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (stall_style)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every popped token against the oldest owed one
   // ---------------------------------------------------------------------
   tok_type want;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_toks.size() == 0) begin
            $error("unexpected token: type %0d start %0d length %0d",
                   rsp_token_type, rsp_text_start, rsp_text_length);
            errors++;
         end else begin
            want = expected_toks.pop_front();
            tokens_checked++;
            if (rsp_token_type !== want.kind) begin
               $error("token_type: expected %0d, got %0d", want.kind, rsp_token_type);
               errors++;
            end
            if (rsp_number_value !== want.value) begin
               $error("number_value: expected %0d, got %0d",
                      $signed(want.value), rsp_number_value);
               errors++;
            end
            if (rsp_text_start !== want.start) begin
               $error("text_start: expected %0d, got %0d", want.start, rsp_text_start);
               errors++;
            end
            if (rsp_text_length !== want.length) begin
               $error("text_length: expected %0d, got %0d", want.length, rsp_text_length);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // run control
   // ---------------------------------------------------------------------
   initial begin
      build_source();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // all words in and every owed token out, then watch for stragglers
      while (accepted_words != total_words || expected_toks.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("ran %0d source words through the lexer, %0d tokens checked",
               total_words, tokens_checked);
      $display("input side held off by a full block for %0d cycles", full_cycles);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout: %0d of %0d words accepted, %0d tokens outstanding",
               accepted_words, total_words, expected_toks.size());
      $display("FAILURE");
      $finish;
   end

endmodule
